### hw/rtl/dpb_pkg.sv
// Shared types and constants for the depth pixel back-projection block.
// Used by the square-root cells, the divider cells and the top level.
`default_nettype none
package dpb_pkg;

    localparam int CFG_AW      = 5;
    localparam int MAG_W       = 48;   // |dx|*fy, |dy|*fx, fx*fy
    localparam int NORM_W      = 30;   // components after normalisation
    localparam int SHIFT_W     = 5;
    localparam int SQ_W        = 63;   // sum of squares and root working width
    localparam int PROD_W      = 46;   // depth times normalised component
    localparam int ROOT_W      = 31;
    localparam int ROOT_STEPS  = 31;
    localparam int DEN_W       = 32;
    localparam int NUM_W       = 57;
    localparam int QUO_W       = 25;
    localparam int OUT_TDATA_W = 80;

    localparam logic [2:0] REG_FOCAL_X   = 3'd0;
    localparam logic [2:0] REG_FOCAL_Y   = 3'd1;
    localparam logic [2:0] REG_CENTER_X  = 3'd2;
    localparam logic [2:0] REG_CENTER_Y  = 3'd3;
    localparam logic [2:0] REG_RANGE_MIN = 3'd4;
    localparam logic [2:0] REG_RANGE_MAX = 3'd5;

    typedef struct packed {
        logic       vld;
        logic [7:0] label;
        logic       neg_x;
        logic       neg_y;
    } tag_t;

    typedef struct packed {
        tag_t              tag;
        logic [PROD_W-1:0] na;
        logic [PROD_W-1:0] nb;
        logic [PROD_W-1:0] nk;
        logic [SQ_W-1:0]   rem;
        logic [SQ_W-1:0]   root;
    } sq_t;

    typedef struct packed {
        tag_t                       tag;
        logic [DEN_W-1:0]           den;
        logic [2:0][NUM_W-1:0]      rem;
        logic [2:0][QUO_W-1:0]      quo;
    } div_t;

endpackage
`default_nettype wire

### hw/rtl/depth_pixel_backprojection.sv
// Top level of the depth pixel back-projection block: register file, front pipeline,
// square-root and divider cell chains, output register. Depends on dpb_pkg and the cells.
`default_nettype none
// Takes one depth pixel per clock and, for every pixel whose depth is non-zero and within
// the configured range, delivers one camera-frame point (x, y, z in mm, 8 fraction bits,
// rounded to nearest) with its class label; other pixels leave no result. Throughput is
// one pixel per cycle; the path to the output register runs through seven
// front stages, the 31-cell square-root chain, one setup stage and the 25-cell divider
// chain. The whole pipeline stalls while the output register holds an untaken result.
module depth_pixel_backprojection #(
    parameter int COORD_BITS = 12,
    parameter int DEPTH_BITS = 16
) (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      psel,
    input  wire                      penable,
    input  wire                      pwrite,
    input  wire [dpb_pkg::CFG_AW-1:0] paddr,
    input  wire [31:0]               pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,
    input  wire                      s_tvalid,
    output logic                     s_tready,
    // pixel_row, pixel_col, depth_mm from bit 0 up, zero padded to bytes
    input  wire [((2*COORD_BITS+DEPTH_BITS+7)/8)*8-1:0] s_tdata,
    // class_label
    input  wire [7:0]                s_tuser,
    output logic                     m_tvalid,
    input  wire                      m_tready,
    // point_x (25), point_y (25), point_z (24) from bit 0 up, zero padded
    output logic [dpb_pkg::OUT_TDATA_W-1:0] m_tdata,
    // point_label
    output logic [7:0]               m_tuser
);
    import dpb_pkg::*;

    typedef struct packed {
        tag_t        tag;
        logic [15:0] dm;
        logic [23:0] ax;
        logic [23:0] ay;
        logic [23:0] fx;
        logic [23:0] fy;
    } p1_t;

    typedef struct packed {
        tag_t             tag;
        logic [15:0]      dm;
        logic [MAG_W-1:0] ma;
        logic [MAG_W-1:0] mb;
        logic [MAG_W-1:0] mk;
        logic [MAG_W-1:0] mx;
        logic [SHIFT_W-1:0] sh;
    } p2_t;

    typedef struct packed {
        tag_t              tag;
        logic [15:0]       dm;
        logic [NORM_W-1:0] ma;
        logic [NORM_W-1:0] mb;
        logic [NORM_W-1:0] mk;
    } p5_t;

    typedef struct packed {
        tag_t                tag;
        logic [2*NORM_W-1:0] sa;
        logic [2*NORM_W-1:0] sb;
        logic [2*NORM_W-1:0] sk;
        logic [PROD_W-1:0]   na;
        logic [PROD_W-1:0]   nb;
        logic [PROD_W-1:0]   nk;
    } p6_t;

    // ---------------- register file ----------------
    logic [23:0] focal_x_reg, focal_y_reg, center_x_reg, center_y_reg;
    logic [15:0] range_min_reg, range_max_reg;
    logic        cfg_wr;
    logic [2:0]  cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[CFG_AW-1:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focal_x_reg   <= 24'd256;
            focal_y_reg   <= 24'd256;
            center_x_reg  <= '0;
            center_y_reg  <= '0;
            range_min_reg <= '0;
            range_max_reg <= 16'hFFFF;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_FOCAL_X:   focal_x_reg   <= pwdata[23:0];
                REG_FOCAL_Y:   focal_y_reg   <= pwdata[23:0];
                REG_CENTER_X:  center_x_reg  <= pwdata[23:0];
                REG_CENTER_Y:  center_y_reg  <= pwdata[23:0];
                REG_RANGE_MIN: range_min_reg <= pwdata[15:0];
                REG_RANGE_MAX: range_max_reg <= pwdata[15:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_FOCAL_X:   prdata = {8'h00, focal_x_reg};
            REG_FOCAL_Y:   prdata = {8'h00, focal_y_reg};
            REG_CENTER_X:  prdata = {8'h00, center_x_reg};
            REG_CENTER_Y:  prdata = {8'h00, center_y_reg};
            REG_RANGE_MIN: prdata = {16'h0000, range_min_reg};
            REG_RANGE_MAX: prdata = {16'h0000, range_max_reg};
            default:       prdata = '0;
        endcase
    end

    // ---------------- flow control ----------------
    logic m_tvalid_reg;
    logic en;
    logic accept;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;
    assign accept   = s_tvalid && en;

    // ---------------- stage 1: filter and offsets ----------------
    logic [COORD_BITS-1:0] in_row, in_col;
    logic [DEPTH_BITS-1:0] in_depth;
    logic [15:0]           d16;
    logic signed [25:0]    sdx, sdy;
    logic [25:0]           mag_x, mag_y;
    p1_t                   p1_reg, p1_next;

    assign in_row   = s_tdata[COORD_BITS-1:0];
    assign in_col   = s_tdata[2*COORD_BITS-1:COORD_BITS];
    assign in_depth = s_tdata[2*COORD_BITS+DEPTH_BITS-1:2*COORD_BITS];
    assign d16      = 16'(in_depth);

    always_comb
    begin
        sdx   = $signed(26'({in_col, 8'h00})) - $signed({2'b00, center_x_reg});
        sdy   = $signed(26'({in_row, 8'h00})) - $signed({2'b00, center_y_reg});
        mag_x = sdx[25] ? 26'(-sdx) : 26'(sdx);
        mag_y = sdy[25] ? 26'(-sdy) : 26'(sdy);
        p1_next.tag.vld   = accept && (d16 != 16'd0) && (d16 >= range_min_reg)
                            && (d16 <= range_max_reg);
        p1_next.tag.label = s_tuser;
        p1_next.tag.neg_x = sdx[25];
        p1_next.tag.neg_y = sdy[25];
        p1_next.dm        = d16;
        p1_next.ax        = mag_x[23:0];
        p1_next.ay        = mag_y[23:0];
        // A focal length of zero counts as the smallest step.
        p1_next.fx        = (focal_x_reg == 24'd0) ? 24'd1 : focal_x_reg;
        p1_next.fy        = (focal_y_reg == 24'd0) ? 24'd1 : focal_y_reg;
    end

    // ---------------- stages 2 to 5: products, maximum, shift ----------------
    p2_t p2_reg, p3_reg, p4_reg;
    p2_t p2_next, p3_next, p4_next;
    p5_t p5_reg, p5_next;
    logic [5:0] blen;

    always_comb
    begin
        p2_next     = '0;
        p2_next.tag = p1_reg.tag;
        p2_next.dm  = p1_reg.dm;
        p2_next.ma  = p1_reg.ax * p1_reg.fy;
        p2_next.mb  = p1_reg.ay * p1_reg.fx;
        p2_next.mk  = p1_reg.fx * p1_reg.fy;

        p3_next    = p2_reg;
        p3_next.mx = p2_reg.ma;
        if (p2_reg.mb > p3_next.mx)
        begin
            p3_next.mx = p2_reg.mb;
        end
        if (p2_reg.mk > p3_next.mx)
        begin
            p3_next.mx = p2_reg.mk;
        end

        blen = '0;
        for (int i = 0; i < MAG_W; i++)
        begin
            if (p3_reg.mx[i])
            begin
                blen = 6'(i + 1);
            end
        end
        p4_next    = p3_reg;
        p4_next.sh = (blen > 6'(NORM_W)) ? SHIFT_W'(blen - 6'(NORM_W)) : '0;

        p5_next.tag = p4_reg.tag;
        p5_next.dm  = p4_reg.dm;
        p5_next.ma  = NORM_W'(p4_reg.ma >> p4_reg.sh);
        p5_next.mb  = NORM_W'(p4_reg.mb >> p4_reg.sh);
        p5_next.mk  = NORM_W'(p4_reg.mk >> p4_reg.sh);
    end

    // ---------------- stage 6: squares and depth products ----------------
    p6_t p6_reg, p6_next;
    sq_t sq_start;

    always_comb
    begin
        p6_next.tag = p5_reg.tag;
        p6_next.sa  = p5_reg.ma * p5_reg.ma;
        p6_next.sb  = p5_reg.mb * p5_reg.mb;
        p6_next.sk  = p5_reg.mk * p5_reg.mk;
        p6_next.na  = p5_reg.dm * p5_reg.ma;
        p6_next.nb  = p5_reg.dm * p5_reg.mb;
        p6_next.nk  = p5_reg.dm * p5_reg.mk;
    end

    // stage 7: sum of squares enters the root chain
    sq_t sq_reg, sq_next;

    always_comb
    begin
        sq_next.tag  = p6_reg.tag;
        sq_next.na   = p6_reg.na;
        sq_next.nb   = p6_reg.nb;
        sq_next.nk   = p6_reg.nk;
        sq_next.rem  = SQ_W'(p6_reg.sa) + SQ_W'(p6_reg.sb) + SQ_W'(p6_reg.sk);
        sq_next.root = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_reg <= '0;
            p2_reg <= '0;
            p3_reg <= '0;
            p4_reg <= '0;
            p5_reg <= '0;
            p6_reg <= '0;
            sq_reg <= '0;
        end
        else if (en)
        begin
            p1_reg <= p1_next;
            p2_reg <= p2_next;
            p3_reg <= p3_next;
            p4_reg <= p4_next;
            p5_reg <= p5_next;
            p6_reg <= p6_next;
            sq_reg <= sq_next;
        end
    end

    assign sq_start = sq_reg;

    // ---------------- square-root chain ----------------
    sq_t sq_chain [0:ROOT_STEPS];
    assign sq_chain[0] = sq_start;

    for (genvar g = 0; g < ROOT_STEPS; g++)
    begin : g_sqrt
        dpb_sqrt_cell #(
            .STEP(ROOT_STEPS - 1 - g)
        ) u_cell (
            .clk  (clk),
            .rst_n(rst_n),
            .en   (en),
            .din  (sq_chain[g]),
            .dout (sq_chain[g+1])
        );
    end

    // ---------------- divider setup ----------------
    // Rounded quotient: (2*256*d*m + R) / (2*R).
    div_t            dv_reg, dv_next;
    logic [ROOT_W-1:0] root_v;

    always_comb
    begin
        root_v         = sq_chain[ROOT_STEPS].root[ROOT_W-1:0];
        dv_next.tag    = sq_chain[ROOT_STEPS].tag;
        dv_next.den    = {root_v, 1'b0};
        dv_next.rem[0] = (NUM_W'(sq_chain[ROOT_STEPS].na) << 9) + NUM_W'(root_v);
        dv_next.rem[1] = (NUM_W'(sq_chain[ROOT_STEPS].nb) << 9) + NUM_W'(root_v);
        dv_next.rem[2] = (NUM_W'(sq_chain[ROOT_STEPS].nk) << 9) + NUM_W'(root_v);
        dv_next.quo    = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_reg <= '0;
        end
        else if (en)
        begin
            dv_reg <= dv_next;
        end
    end

    div_t dv_chain [0:QUO_W];
    assign dv_chain[0] = dv_reg;

    for (genvar g = 0; g < QUO_W; g++)
    begin : g_div
        dpb_div_cell #(
            .BITP(QUO_W - 1 - g)
        ) u_cell (
            .clk  (clk),
            .rst_n(rst_n),
            .en   (en),
            .din  (dv_chain[g]),
            .dout (dv_chain[g+1])
        );
    end

    // ---------------- output register ----------------
    div_t                   dv_last;
    logic [QUO_W-1:0]       px, py;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;
    logic [7:0]             m_tuser_reg;

    assign dv_last = dv_chain[QUO_W];
    assign px      = dv_last.tag.neg_x ? QUO_W'(-dv_last.quo[0]) : dv_last.quo[0];
    assign py      = dv_last.tag.neg_y ? QUO_W'(-dv_last.quo[1]) : dv_last.quo[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (en)
        begin
            m_tvalid_reg <= dv_last.tag.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_tdata_reg <= {6'd0, dv_last.quo[2][23:0], py, px};
            m_tuser_reg <= dv_last.tag.label;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef ASSERT_OFF
    a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && d16 == 16'd0) |=> !p1_reg.tag.vld)
        else $error("zero-depth pixel entered the pipeline");

    a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(p1_reg) && $stable(dv_reg))
        else $error("pipeline moved during a stall");

    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        dv_last.tag.vld |-> (dv_last.rem[0] < NUM_W'(dv_last.den))
            && (dv_last.rem[1] < NUM_W'(dv_last.den))
            && (dv_last.rem[2] < NUM_W'(dv_last.den)))
        else $error("divider remainder not below divisor");
`endif

endmodule
`default_nettype wire

### hw/rtl/dpb_sqrt_cell.sv
// One step of the pipelined integer square root: settles one root bit.
// Depends on dpb_pkg for the sq_t payload.
`default_nettype none
module dpb_sqrt_cell #(
    parameter int STEP = 0
) (
    input  wire            clk,
    input  wire            rst_n,
    input  wire            en,
    input  dpb_pkg::sq_t   din,
    output dpb_pkg::sq_t   dout
);
    import dpb_pkg::*;

    localparam logic [SQ_W-1:0] BIT_V = SQ_W'(1) << (2 * STEP);

    sq_t             cell_reg;
    sq_t             cell_next;
    logic [SQ_W-1:0] trial;

    always_comb
    begin
        cell_next = din;
        trial     = din.root + BIT_V;
        if (din.rem >= trial)
        begin
            cell_next.rem  = din.rem - trial;
            cell_next.root = (din.root >> 1) + BIT_V;
        end
        else
        begin
            cell_next.root = din.root >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_reg <= '0;
        end
        else if (en)
        begin
            cell_reg <= cell_next;
        end
    end

    assign dout = cell_reg;

endmodule
`default_nettype wire

### hw/rtl/dpb_div_cell.sv
// One step of the pipelined restoring divider: one quotient bit for all three lanes.
// Depends on dpb_pkg for the div_t payload.
`default_nettype none
module dpb_div_cell #(
    parameter int BITP = 0
) (
    input  wire            clk,
    input  wire            rst_n,
    input  wire            en,
    input  dpb_pkg::div_t  din,
    output dpb_pkg::div_t  dout
);
    import dpb_pkg::*;

    div_t             cell_reg;
    div_t             cell_next;
    logic [NUM_W-1:0] shifted;

    always_comb
    begin
        cell_next = din;
        shifted   = NUM_W'(din.den) << BITP;
        for (int i = 0; i < 3; i++)
        begin
            if (din.rem[i] >= shifted)
            begin
                cell_next.rem[i]       = din.rem[i] - shifted;
                cell_next.quo[i][BITP] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_reg <= '0;
        end
        else if (en)
        begin
            cell_reg <= cell_next;
        end
    end

    assign dout = cell_reg;

endmodule
`default_nettype wire

### sim/depth_pixel_backprojection_tb.sv
// Self-checking testbench for depth_pixel_backprojection: register writes over APB,
// depth pixels in on the slave stream, points checked on the master stream.
// Depends on dpb_pkg and the block's RTL only.
`timescale 1ns / 1ps

module depth_pixel_backprojection_tb;
    import dpb_pkg::*;

    typedef struct {
        logic [24:0] x;
        logic [24:0] y;
        logic [23:0] z;
        logic [7:0]  label;
    } point_t;

    logic        clk;
    logic        rst_n;
    logic        psel, penable, pwrite;
    logic [CFG_AW-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid, s_tready;
    logic [39:0] s_tdata;   // pixel_row[11:0], pixel_col[23:12], depth_mm[39:24]
    logic [7:0]  s_tuser;   // class_label
    logic        m_tvalid, m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;  // point_x[24:0], point_y[49:25], point_z[73:50]
    logic [7:0]  m_tuser;   // point_label

    // Shadow copy of the camera registers.
    logic [23:0] cam_fx, cam_fy, cam_cx, cam_cy;
    logic [15:0] depth_lo, depth_hi;

    point_t      pending_points[$];
    int          fail_count;
    int          pixels_sent;
    int          points_seen;
    int          burst_left;
    int          stall_mode;
    int          stall_phase;

    depth_pixel_backprojection dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned bit_w;
        root = 0;
        bit_w = 64'd1 << 62;
        while (bit_w > v)
            bit_w >>= 2;
        while (bit_w != 0)
        begin
            if (v >= root + bit_w)
            begin
                v -= root + bit_w;
                root = (root >> 1) + bit_w;
            end
            else
                root >>= 1;
            bit_w >>= 2;
        end
        return root;
    endfunction

    function automatic longint unsigned scaled_round(longint unsigned d, longint unsigned m,
                                                     longint unsigned len);
        longint unsigned num;
        num = d * 256 * m;
        return (2 * num + len) / (2 * len);
    endfunction

    // Back-projects one pixel; returns 0 when the pixel is dropped.
    function automatic bit project_pixel(logic [11:0] row, logic [11:0] col, logic [15:0] d,
                                         logic [7:0] label, output point_t pt);
        longint unsigned fx, fy, ma, mb, mk, mx, len;
        longint          dx, dy;
        logic [24:0]     mag;
        int              s;
        if (d == 0 || d < depth_lo || d > depth_hi)
            return 0;
        fx = (cam_fx == 0) ? 1 : cam_fx;
        fy = (cam_fy == 0) ? 1 : cam_fy;
        dx = longint'({col, 8'h00}) - longint'(cam_cx);
        dy = longint'({row, 8'h00}) - longint'(cam_cy);
        ma = ((dx < 0) ? -dx : dx) * fy;
        mb = ((dy < 0) ? -dy : dy) * fx;
        mk = fx * fy;
        mx = ma;
        if (mb > mx) mx = mb;
        if (mk > mx) mx = mk;
        s = 0;
        while ((mx >> s) >= (64'd1 << 30))
            s++;
        ma >>= s;
        mb >>= s;
        mk >>= s;
        len = int_sqrt(ma * ma + mb * mb + mk * mk);
        mag = 25'(scaled_round(d, ma, len));
        pt.x = (dx < 0) ? -mag : mag;
        mag = 25'(scaled_round(d, mb, len));
        pt.y = (dy < 0) ? -mag : mag;
        pt.z = 24'(scaled_round(d, mk, len));
        pt.label = label;
        return 1;
    endfunction

    // Receiver stall pattern: switches at random among always ready, coin toss and one in three.
    always @(negedge clk)
    begin
        stall_phase <= stall_phase + 1;
        if (stall_phase % 97 == 0)
            stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            default: m_tready <= (stall_phase % 3 == 0);
        endcase
    end

    always @(posedge clk)
    begin
        point_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            points_seen++;
            if (pending_points.size() == 0)
            begin
                $error("point with no pixel waiting: tdata=%h label=%h", m_tdata, m_tuser);
                fail_count++;
            end
            else
            begin
                want = pending_points.pop_front();
                if (m_tdata[24:0] !== want.x)
                begin
                    $error("point_x expected %h got %h", want.x, m_tdata[24:0]);
                    fail_count++;
                end
                if (m_tdata[49:25] !== want.y)
                begin
                    $error("point_y expected %h got %h", want.y, m_tdata[49:25]);
                    fail_count++;
                end
                if (m_tdata[73:50] !== want.z)
                begin
                    $error("point_z expected %h got %h", want.z, m_tdata[73:50]);
                    fail_count++;
                end
                if (m_tuser !== want.label)
                begin
                    $error("point_label expected %h got %h", want.label, m_tuser);
                    fail_count++;
                end
            end
        end
    end

    // Called and returns at a falling edge.
    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = CFG_AW'(idx) << 2;
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        case (idx)
            REG_FOCAL_X:   cam_fx = value[23:0];
            REG_FOCAL_Y:   cam_fy = value[23:0];
            REG_CENTER_X:  cam_cx = value[23:0];
            REG_CENTER_Y:  cam_cy = value[23:0];
            REG_RANGE_MIN: depth_lo = value[15:0];
            REG_RANGE_MAX: depth_hi = value[15:0];
            default: ;
        endcase
    endtask

    task automatic set_camera(logic [31:0] fx, logic [31:0] fy, logic [31:0] cx,
                              logic [31:0] cy, logic [31:0] lo, logic [31:0] hi);
        write_reg(REG_FOCAL_X, fx);
        write_reg(REG_FOCAL_Y, fy);
        write_reg(REG_CENTER_X, cx);
        write_reg(REG_CENTER_Y, cy);
        write_reg(REG_RANGE_MIN, lo);
        write_reg(REG_RANGE_MAX, hi);
    endtask

    // Sends one pixel in bursts with random gaps; returns at a falling edge.
    task automatic send_pixel(logic [11:0] row, logic [11:0] col, logic [15:0] d,
                              logic [7:0] label);
        point_t pt;
        int     gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_tvalid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_tvalid = 1'b1;
        s_tdata = {d, col, row};
        s_tuser = label;
        do
            @(posedge clk);
        while (!s_tready);
        if (project_pixel(row, col, d, label, pt))
            pending_points.insert(pending_points.size(), pt);
        pixels_sent++;
        @(negedge clk);
    endtask

    // Lets the pipeline empty, dropped pixels included, before registers change.
    task automatic drain;
        s_tvalid = 1'b0;
        while (pending_points.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic test_default_corners;
        send_pixel(12'd0, 12'd0, 16'd1, 8'd0);
        send_pixel(12'd4095, 12'd4095, 16'd65535, 8'd255);
        send_pixel(12'd0, 12'd4095, 16'd1000, 8'd17);
        send_pixel(12'd4095, 12'd0, 16'd32768, 8'd128);
        send_pixel(12'd100, 12'd200, 16'd0, 8'd5);
        drain();
    endtask

    task automatic test_depth_window;
        set_camera(32'd128000, 32'd128000, 32'd81920, 32'd61440, 32'd1000, 32'd2000);
        send_pixel(12'd240, 12'd320, 16'd999, 8'd1);
        send_pixel(12'd240, 12'd320, 16'd1000, 8'd2);
        send_pixel(12'd10, 12'd630, 16'd2000, 8'd3);
        send_pixel(12'd470, 12'd5, 16'd2001, 8'd4);
        send_pixel(12'd0, 12'd0, 16'd0, 8'd6);
        drain();
        // An inverted window drops everything.
        write_reg(REG_RANGE_MIN, 32'd3000);
        send_pixel(12'd240, 12'd320, 16'd1500, 8'd7);
        send_pixel(12'd240, 12'd320, 16'd3000, 8'd8);
        drain();
    endtask

    task automatic test_extreme_intrinsics;
        // Zero focal lengths, with junk in the unused upper bits, count as one.
        set_camera(32'hFF00_0000, 32'hAB00_0000, 32'd0, 32'hFFFF_FFFF,
                   32'hFFFF_0000, 32'h0000_FFFF);
        send_pixel(12'd0, 12'd4095, 16'd65535, 8'd9);
        send_pixel(12'd4095, 12'd0, 16'd1, 8'd10);
        send_pixel(12'd0, 12'd0, 16'd65535, 8'd11);
        drain();
        set_camera(32'hFFFFFF, 32'hFFFFFF, 32'hFFFFFF, 32'd0, 32'd65535, 32'd65535);
        send_pixel(12'd4095, 12'd4095, 16'd65535, 8'd12);
        send_pixel(12'd0, 12'd0, 16'd65535, 8'd13);
        send_pixel(12'd2048, 12'd2048, 16'd65534, 8'd14);
        drain();
        set_camera(32'd1, 32'hFFFFFF, 32'd524288, 32'd524288, 32'd0, 32'd65535);
        send_pixel(12'd4095, 12'd0, 16'd40000, 8'd15);
        send_pixel(12'd2048, 12'd2048, 16'd40000, 8'd16);
        drain();
    endtask

    task automatic test_random_frames;
        logic [15:0] d, lo, hi;
        for (int frame = 0; frame < 6; frame++)
        begin
            lo = 16'(($urandom_range(0, 2) == 0) ? $urandom_range(0, 65535)
                                                 : $urandom_range(0, 500));
            hi = 16'(($urandom_range(0, 2) == 0) ? $urandom_range(0, 65535)
                                                 : $urandom_range(20000, 65535));
            if (frame == 5)
                set_camera($urandom(), $urandom(), $urandom(), $urandom(), 0, 65535);
            else
                set_camera($urandom_range(1000, 400000), $urandom_range(1000, 400000),
                           $urandom_range(0, 1048575), $urandom_range(0, 1048575), lo, hi);
            for (int n = 0; n < 320; n++)
            begin
                case ($urandom_range(0, 9))
                    0: d = 16'd0;
                    1: d = depth_lo;
                    2: d = depth_hi;
                    3: d = 16'($urandom());
                    default: d = 16'((depth_hi > depth_lo)
                                     ? $urandom_range(depth_lo, depth_hi) : $urandom());
                endcase
                send_pixel(12'($urandom()), 12'($urandom()), d, 8'($urandom()));
            end
            drain();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        stall_mode = 0;
        stall_phase = 0;
        fail_count = 0;
        pixels_sent = 0;
        points_seen = 0;
        burst_left = 0;
        cam_fx = 24'd256;
        cam_fy = 24'd256;
        cam_cx = 24'd0;
        cam_cy = 24'd0;
        depth_lo = 16'd0;
        depth_hi = 16'd65535;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_default_corners();
        test_depth_window();
        test_extreme_intrinsics();
        test_random_frames();

        $display("Sent %0d depth pixels over several camera and range settings,", pixels_sent);
        $display("checked %0d back-projected points.", points_seen);
        if (fail_count == 0)
            $display("depth_pixel_backprojection verification clean");
        else
            $display("depth_pixel_backprojection verification failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("depth_pixel_backprojection verification failed");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/dpb_pkg.sv
hw/rtl/dpb_sqrt_cell.sv
hw/rtl/dpb_div_cell.sv
hw/rtl/depth_pixel_backprojection.sv
sim/depth_pixel_backprojection_tb.sv
